// ----- rtl/gated_nearest_box_tracker_assert.svh -----
// Assertion macros for the gated nearest-box tracker checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef GATED_NEAREST_BOX_TRACKER_ASSERT_SVH
`define GATED_NEAREST_BOX_TRACKER_ASSERT_SVH

// Checked only while out of reset.
`define GNBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GNBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/gnbt_pkg.sv -----
// Shared constants and helpers for the gated nearest-box tracker.
// No dependencies; used by every RTL file of the block.
package gnbt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int GATE_BITS      = 12;
  localparam int MISS_BITS      = 8;
  localparam int VIC_BITS       = 19;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = GATE_BITS;

  localparam logic [GATE_BITS-1:0] GATE_RESET = 12'd120;
  localparam logic [MISS_BITS-1:0] MISS_RESET = 8'd10;
  localparam logic [VIC_BITS-1:0]  VIC_START  = 19'd400000;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GATE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MISS = 2'd1;

  // input commands and result kinds
  localparam logic CMD_BOX      = 1'b0;
  localparam logic CMD_EOF      = 1'b1;
  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // four box edges, padded to whole bytes
  function automatic int in_data_bits(int cb);
    return ((4 * cb + 7) / 8) * 8;
  endfunction

  // result fields without kind: detected, two centres, width, height,
  // column, misses, reset flag
  function automatic int out_field_bits(int cb);
    return 5 * cb + 12;
  endfunction

  function automatic int out_data_bits(int cb);
    return ((out_field_bits(cb) + 7) / 8) * 8;
  endfunction

endpackage

// ----- rtl/gated_nearest_box_tracker.sv -----
// Gated nearest-box tracker, top level: sequencer, tracker state, config
// registers and output register. Uses gnbt_pkg and gnbt_dist.
//
//  channel | direction | payload                                  | handshake
//  in_     | slave     | tuser: command, is_person; tdata: edges  | tvalid/tready
//  out_    | master    | tuser: result_kind; tdata: target fields | tvalid/tready
//  cfg_    | slave     | cfg_index, cfg_data                      | valid/ready
//
// A person box with a reference target waits on the square root loop of
// gnbt_dist, one bit pair a cycle, before its result. Other boxes and
// frame ends skip that loop. One item is in flight at a time; in_tready
// is high only when idle. A stalled result waits in the output register;
// the item after it runs until it too has a result ready. Reset is
// synchronous and needs no sweep.
module gated_nearest_box_tracker #(
  parameter int COORD_BITS = gnbt_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // low up: box_x_min, box_x_max, box_y_min, box_y_max, zero pad
  input  logic [gnbt_pkg::in_data_bits(COORD_BITS)-1:0] in_tdata,
  // low up: command, is_person
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // low up: detected, center_x_half, center_y_half, target_width,
  // target_height, target_column, misses, tracker_reset, zero pad
  output logic [gnbt_pkg::out_data_bits(COORD_BITS)-1:0] out_tdata,
  // low up: result_kind
  output logic out_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [gnbt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [gnbt_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CB  = COORD_BITS;
  localparam int HB  = COORD_BITS + 1;
  localparam int OFW = gnbt_pkg::out_field_bits(COORD_BITS);
  localparam int ODW = gnbt_pkg::out_data_bits(COORD_BITS);
  localparam int VB  = gnbt_pkg::VIC_BITS;
  localparam int GB  = gnbt_pkg::GATE_BITS;
  localparam int MB  = gnbt_pkg::MISS_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIST = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t          state_r;
  logic [GB-1:0]   gate_r;
  logic [MB-1:0]   limit_r;
  logic            armed_r;
  logic            found_r;
  logic [HB-1:0]   cur_cx_r;
  logic [HB-1:0]   cur_cy_r;
  logic [CB-1:0]   cur_w_r;
  logic [CB-1:0]   cur_h_r;
  logic [HB-1:0]   last_cx_r;
  logic [HB-1:0]   last_cy_r;
  logic            last_nz_r;
  logic [VB-1:0]   best_r;
  logic [MB-1:0]   miss_r;
  logic [VB-1:0]   vic_r;
  logic            out_valid_r;
  logic [ODW-1:0]  out_data_r;
  logic            out_kind_r;

  // latched item
  logic            cmd_r;
  logic            person_r;
  logic [HB-1:0]   cx_r;
  logic [HB-1:0]   cy_r;
  logic [CB-1:0]   w_r;
  logic [CB-1:0]   h_r;

  logic [CB-1:0]   x0, x1, y0, y1;
  logic [CB-1:0]   w_in, h_in;
  logic [HB-1:0]   dx, dy;
  logic            dist_start;
  logic            dist_done;
  logic [HB-1:0]   dist_vic;

  logic            in_acc;
  logic            slot_free;
  logic            is_eof;
  logic            take;
  logic            emit;
  logic            rst_flag;
  logic            armed_nxt;
  logic [MB-1:0]   miss_nxt;
  logic [CB-1:0]   w_nxt;
  logic [CB-1:0]   h_nxt;
  logic [OFW-1:0]  pay;
  logic [ODW-1:0]  out_data_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    x0   = in_tdata[CB-1:0];
    x1   = in_tdata[2*CB-1:CB];
    y0   = in_tdata[3*CB-1:2*CB];
    y1   = in_tdata[4*CB-1:3*CB];
    // saturate inverted boxes to zero size
    w_in = (x1 > x0) ? x1 - x0 : '0;
    h_in = (y1 > y0) ? y1 - y0 : '0;
    dx   = (cx_r >= last_cx_r) ? cx_r - last_cx_r : last_cx_r - cx_r;
    dy   = (cy_r >= last_cy_r) ? cy_r - last_cy_r : last_cy_r - cy_r;
  end

  assign dist_start = (state_r == S_PREP) && person_r && last_nz_r;

  gnbt_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dist_start),
    .dx   (dx),
    .dy   (dy),
    .done (dist_done),
    .vic  (dist_vic)
  );

  // close of an item: frame summary or box decision
  always_comb begin
    is_eof    = (cmd_r == gnbt_pkg::CMD_EOF);
    take      = (vic_r < VB'(gate_r)) && (vic_r < best_r);
    emit      = is_eof || take;
    rst_flag  = 1'b0;
    armed_nxt = armed_r;
    miss_nxt  = miss_r;
    w_nxt     = cur_w_r;
    h_nxt     = cur_h_r;
    if (is_eof) begin
      if (!found_r) begin
        if (miss_r < limit_r) begin
          miss_nxt = miss_r + 1'b1;
        end else begin
          miss_nxt  = '0;
          w_nxt     = '0;
          h_nxt     = '0;
          armed_nxt = 1'b0;
          rst_flag  = 1'b1;
        end
      end else begin
        miss_nxt = '0;
      end
      pay = {rst_flag, miss_nxt, cur_cx_r[HB-1:1], h_nxt, w_nxt,
             cur_cy_r, cur_cx_r, found_r};
    end else begin
      pay = {1'b0, miss_r, cx_r[HB-1:1], h_r, w_r, cy_r, cx_r, 1'b1};
    end
    out_data_nxt           = '0;
    out_data_nxt[OFW-1:0]  = pay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gate_r      <= gnbt_pkg::GATE_RESET;
      limit_r     <= gnbt_pkg::MISS_RESET;
      armed_r     <= 1'b0;
      found_r     <= 1'b0;
      cur_cx_r    <= '0;
      cur_cy_r    <= '0;
      cur_w_r     <= '0;
      cur_h_r     <= '0;
      last_cx_r   <= '0;
      last_cy_r   <= '0;
      last_nz_r   <= 1'b0;
      best_r      <= gnbt_pkg::VIC_START;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gnbt_pkg::CFG_GATE: gate_r  <= cfg_data;
          gnbt_pkg::CFG_MISS: limit_r <= cfg_data[MB-1:0];
          default: ;
        endcase
      end
      if (state_r == S_FIN && slot_free && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            // rearm the tracker on the first item after it reset itself
            if (!armed_r) begin
              armed_r   <= 1'b1;
              cur_cx_r  <= '0;
              cur_cy_r  <= '0;
              cur_w_r   <= '0;
              cur_h_r   <= '0;
              last_nz_r <= 1'b0;
              miss_r    <= '0;
              best_r    <= gnbt_pkg::VIC_START;
            end
            state_r <= (in_tuser[0] == gnbt_pkg::CMD_EOF) ? S_FIN : S_PREP;
          end
        end
        S_PREP: begin
          if (!person_r) begin
            state_r <= S_IDLE;
          end else if (last_nz_r) begin
            state_r <= S_DIST;
          end else begin
            // no reference yet: place the box just inside the gate
            last_nz_r <= (w_r != '0) && (h_r != '0);
            state_r   <= S_FIN;
          end
        end
        S_DIST: begin
          if (dist_done) state_r <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            state_r <= S_IDLE;
            if (is_eof) begin
              miss_r    <= miss_nxt;
              cur_w_r   <= w_nxt;
              cur_h_r   <= h_nxt;
              armed_r   <= armed_nxt;
              last_cx_r <= cur_cx_r;
              last_cy_r <= cur_cy_r;
              last_nz_r <= (w_nxt != '0) && (h_nxt != '0);
              best_r    <= gnbt_pkg::VIC_START;
              found_r   <= 1'b0;
            end else if (take) begin
              best_r   <= vic_r;
              cur_cx_r <= cx_r;
              cur_cy_r <= cy_r;
              cur_w_r  <= w_r;
              cur_h_r  <= h_r;
              found_r  <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_tuser[0];
      person_r <= in_tuser[1];
      w_r      <= w_in;
      h_r      <= h_in;
      cx_r     <= {x0, 1'b0} + HB'(w_in);
      cy_r     <= {y0, 1'b0} + HB'(h_in);
    end
    if (state_r == S_PREP) begin
      vic_r <= (gate_r != '0) ? VB'(gate_r - GB'(1)) : '0;
    end
    if (state_r == S_DIST && dist_done) begin
      vic_r <= VB'(dist_vic);
    end
    if (state_r == S_FIN && slot_free && emit) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= is_eof ? gnbt_pkg::KIND_SUMMARY : gnbt_pkg::KIND_UPDATE;
    end
  end

endmodule

// ----- rtl/gnbt_dist.sv -----
// Centre distance unit: one shared multiplier squares dx then dy, then one
// subtract-and-compare stage iterates the integer square root. Uses gnbt_pkg.
module gnbt_dist #(
  parameter int COORD_BITS = gnbt_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [COORD_BITS:0] dx,
  input  logic [COORD_BITS:0] dy,
  output logic                done,
  output logic [COORD_BITS:0] vic
);

  localparam int HB = COORD_BITS + 1;
  localparam int K  = COORD_BITS + 2;
  localparam int SQ = 2 * K;
  localparam logic [SQ-1:0] BIT_TOP = {2'b01, {(SQ - 2){1'b0}}};

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MULX = 4'b0010,
    D_MULY = 4'b0100,
    D_ROOT = 4'b1000
  } dstate_t;

  dstate_t         state_r;
  logic            done_r;
  logic [HB-1:0]   op_x_r;
  logic [HB-1:0]   op_y_r;
  logic [SQ-1:0]   acc_r;
  logic [SQ-1:0]   root_r;
  logic [SQ-1:0]   bit_r;

  logic [HB-1:0]   mul_op;
  logic [2*HB-1:0] prod;
  logic [SQ-1:0]   trial;
  logic            fits;

  always_comb begin
    mul_op = (state_r == D_MULX) ? op_x_r : op_y_r;
    prod   = mul_op * mul_op;
    trial  = root_r + bit_r;
    fits   = (acc_r >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) state_r <= D_MULX;
        end
        D_MULX: state_r <= D_MULY;
        D_MULY: state_r <= D_ROOT;
        D_ROOT: begin
          if (bit_r[0]) begin
            state_r <= D_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          op_x_r <= dx;
          op_y_r <= dy;
        end
      end
      D_MULX: acc_r <= SQ'(prod);
      D_MULY: begin
        acc_r  <= acc_r + SQ'(prod);
        root_r <= '0;
        bit_r  <= BIT_TOP;
      end
      D_ROOT: begin
        if (fits) begin
          acc_r  <= acc_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  // whole pixels: drop the half-pixel bit of the root
  assign vic  = root_r[K-1:1];

endmodule

// ----- rtl/gnbt_checker.sv -----
// Port-level checker for the gated nearest-box tracker, bound to the top.
// Uses gnbt_pkg and the macros of gated_nearest_box_tracker_assert.svh.
`include "gated_nearest_box_tracker_assert.svh"

module gnbt_checker #(
  parameter int COORD_BITS = gnbt_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [gnbt_pkg::out_data_bits(COORD_BITS)-1:0] out_tdata,
  input logic out_tuser
);

  // hold a stalled result
  `GNBT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // one item at a time: ready drops after every accepted item
  `GNBT_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "second item taken while busy")

  // reset empties the output register
  `GNBT_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "result left valid over reset")

endmodule

bind gated_nearest_box_tracker gnbt_checker #(.COORD_BITS(COORD_BITS)) u_gnbt_checker (.*);

// ----- tb/gated_nearest_box_tracker_test.sv -----
// Self-checking bench for gated_nearest_box_tracker: a directed script, then
// framed random detector traffic, checked against a behavioural tracker model.
// Depends on gnbt_pkg and the tracker RTL only.
module gated_nearest_box_tracker_test;

  localparam int CB          = 12;
  localparam int IN_W        = gnbt_pkg::in_data_bits(CB);
  localparam int OUT_W       = gnbt_pkg::out_data_bits(CB);
  localparam int FIELD_W     = 5 * CB + 12;
  localparam int SETTLE      = 32;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic          cmd;
    logic          person;
    logic [CB-1:0] x0;
    logic [CB-1:0] x1;
    logic [CB-1:0] y0;
    logic [CB-1:0] y1;
  } det_item_t;

  typedef struct packed {
    logic          kind;
    logic          detected;
    logic [CB:0]   cx;
    logic [CB:0]   cy;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
    logic [CB-1:0] col;
    logic [7:0]    misses;
    logic          rst;
  } track_report_t;

  // out_tdata layout, msb first; whole bytes at this coordinate width
  typedef struct packed {
    logic                     rst;
    logic [7:0]               misses;
    logic [CB-1:0]            col;
    logic [CB-1:0]            h;
    logic [CB-1:0]            w;
    logic [CB:0]              cy;
    logic [CB:0]              cx;
    logic                     detected;
  } out_word_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                                reg_kind_dummy_unused_never;
  } unused_never_t;

  typedef struct {
    row_kind_t                                kind;
    det_item_t                                item;
    logic [gnbt_pkg::CFG_IDX_BITS-1:0]        reg_idx;
    logic [gnbt_pkg::CFG_DATA_BITS-1:0]       reg_val;
    bit                                       typed;
    track_report_t                            want;
  } script_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [IN_W-1:0]                    in_tdata = '0;
  logic [1:0]                         in_tuser = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [OUT_W-1:0]                   out_tdata;
  logic                               out_tuser;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [gnbt_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [gnbt_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  // model of the tracker state and registers
  logic          trk_armed = 1'b0;
  logic          trk_found = 1'b0;
  logic [CB:0]   tgt_cx = '0;
  logic [CB:0]   tgt_cy = '0;
  logic [CB-1:0] tgt_w = '0;
  logic [CB-1:0] tgt_h = '0;
  logic [CB:0]   ref_cx = '0;
  logic [CB:0]   ref_cy = '0;
  logic          ref_valid = 1'b0;
  int            best_dist = int'(gnbt_pkg::VIC_START);
  logic [7:0]    miss_cnt = '0;
  logic [11:0]   gate_cfg = gnbt_pkg::GATE_RESET;
  logic [7:0]    miss_cfg = gnbt_pkg::MISS_RESET;

  track_report_t tracker_reports[$];
  script_row_t   script[$];
  int            fault_count = 0;
  int            burst_left = 0;
  int            gap_next = 0;
  int            ready_left = 0;
  int            ready_sel;
  int            idle_cycles = 0;
  int            sc_x = 1000;
  int            sc_y = 700;
  int            sc_w = 120;
  int            sc_h = 240;
  track_report_t head;

  gated_nearest_box_tracker #(.COORD_BITS(CB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned isqrt(input longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return int'(root);
  endfunction

  function automatic track_report_t snapshot(input logic kind, input logic rst);
    track_report_t r;
    r.kind     = kind;
    r.detected = trk_found;
    r.cx       = tgt_cx;
    r.cy       = tgt_cy;
    r.w        = tgt_w;
    r.h        = tgt_h;
    r.col      = tgt_cx[CB:1];
    r.misses   = miss_cnt;
    r.rst      = rst;
    return r;
  endfunction

  // advance the model by one item; returns 1 when the item yields a report
  function automatic bit step_tracker(input det_item_t it, output track_report_t res);
    int  w, h, cx, cy, dx, dy, sep;
    bit  in_gate;
    logic rst_flag;
    res = '0;
    if (!trk_armed) begin
      trk_armed = 1'b1;
      tgt_cx    = '0;
      tgt_cy    = '0;
      tgt_w     = '0;
      tgt_h     = '0;
      ref_valid = 1'b0;
      miss_cnt  = '0;
      best_dist = int'(gnbt_pkg::VIC_START);
    end
    if (it.cmd == gnbt_pkg::CMD_BOX) begin
      if (!it.person) return 1'b0;
      w  = (it.x1 > it.x0) ? int'(it.x1) - int'(it.x0) : 0;
      h  = (it.y1 > it.y0) ? int'(it.y1) - int'(it.y0) : 0;
      cx = 2 * int'(it.x0) + w;
      cy = 2 * int'(it.y0) + h;
      if (ref_valid) begin
        dx = cx - int'(ref_cx);
        dy = cy - int'(ref_cy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sep     = int'(isqrt(longint'(dx) * dx + longint'(dy) * dy) >> 1);
        in_gate = sep < int'(gate_cfg);
      end else begin
        // no reference target yet: take the box just inside the gate
        ref_valid = (w != 0) && (h != 0);
        in_gate   = gate_cfg != 0;
        sep       = in_gate ? int'(gate_cfg) - 1 : 0;
      end
      if (!in_gate || sep >= best_dist) return 1'b0;
      best_dist = sep;
      tgt_cx    = cx[CB:0];
      tgt_cy    = cy[CB:0];
      tgt_w     = w[CB-1:0];
      tgt_h     = h[CB-1:0];
      trk_found = 1'b1;
      res = snapshot(gnbt_pkg::KIND_UPDATE, 1'b0);
      return 1'b1;
    end
    rst_flag = 1'b0;
    if (!trk_found) begin
      if (miss_cnt < miss_cfg) begin
        miss_cnt = miss_cnt + 8'd1;
      end else begin
        miss_cnt  = '0;
        tgt_w     = '0;
        tgt_h     = '0;
        trk_armed = 1'b0;
        rst_flag  = 1'b1;
      end
    end else begin
      miss_cnt = '0;
    end
    ref_cx    = tgt_cx;
    ref_cy    = tgt_cy;
    ref_valid = (tgt_w != 0) && (tgt_h != 0);
    best_dist = int'(gnbt_pkg::VIC_START);
    res = snapshot(gnbt_pkg::KIND_SUMMARY, rst_flag);
    trk_found = 1'b0;
    return 1'b1;
  endfunction

  function automatic det_item_t mk_item(input logic cmd, input logic person,
                                        input int x0, input int x1,
                                        input int y0, input int y1);
    det_item_t it;
    it.cmd    = cmd;
    it.person = person;
    it.x0     = x0[CB-1:0];
    it.x1     = x1[CB-1:0];
    it.y0     = y0[CB-1:0];
    it.y1     = y1[CB-1:0];
    return it;
  endfunction

  function automatic track_report_t mk_report(input logic kind, input logic det,
                                              input int cx, input int cy,
                                              input int w, input int h,
                                              input int misses, input logic rst);
    track_report_t r;
    r.kind     = kind;
    r.detected = det;
    r.cx       = cx[CB:0];
    r.cy       = cy[CB:0];
    r.w        = w[CB-1:0];
    r.h        = h[CB-1:0];
    r.col      = cx[CB:1];
    r.misses   = misses[7:0];
    r.rst      = rst;
    return r;
  endfunction

  function automatic void add_item(input det_item_t it);
    script_row_t row;
    row.kind    = ROW_ITEM;
    row.item    = it;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    script = {script, row};
  endfunction

  function automatic void add_reg(input logic [gnbt_pkg::CFG_IDX_BITS-1:0] idx,
                                  input int val);
    script_row_t row;
    row.kind    = ROW_REG;
    row.item    = '0;
    row.reg_idx = idx;
    row.reg_val = val[gnbt_pkg::CFG_DATA_BITS-1:0];
    row.typed   = 1'b0;
    row.want    = '0;
    script = {script, row};
  endfunction

  // attach a hand-computed report to the last scripted item
  function automatic void add_report(input track_report_t r);
    script[$].typed = 1'b1;
    script[$].want  = r;
  endfunction

  function automatic int clip(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  function automatic det_item_t random_box();
    int sel, jit, cx, cy, hw, hh, a, b;
    det_item_t it;
    sel = $urandom_range(0, 19);
    jit = (gate_cfg > 12'd400) ? 200 : int'(gate_cfg) / 2 + 3;
    it  = mk_item(gnbt_pkg::CMD_BOX, 1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
    if (sel < 2) begin
      it.person = 1'b0;
    end else if (sel < 13) begin
      cx = sc_x + int'($urandom_range(0, 2 * jit)) - jit;
      cy = sc_y + int'($urandom_range(0, 2 * jit)) - jit;
      hw = sc_w / 2 + int'($urandom_range(0, 6));
      hh = sc_h / 2 + int'($urandom_range(0, 6));
      it = mk_item(gnbt_pkg::CMD_BOX, 1'b1, clip(cx - hw), clip(cx + hw),
                   clip(cy - hh), clip(cy + hh));
    end else if (sel < 17) begin
      // fully random edges: inverted about half of the time
    end else if (sel < 19) begin
      // degenerate: collapsed or inverted near the scene
      a = clip(sc_x + int'($urandom_range(0, 40)) - 20);
      b = clip(sc_y + int'($urandom_range(0, 40)) - 20);
      it = mk_item(gnbt_pkg::CMD_BOX, 1'b1, a, clip(a - int'($urandom_range(0, 30))),
                   b, clip(b + int'($urandom_range(0, 1)) * 50));
    end else begin
      it = mk_item(gnbt_pkg::CMD_BOX, 1'b1, $urandom_range(0, 1) * 4095,
                   $urandom_range(0, 1) * 4095, $urandom_range(0, 1) * 4095,
                   $urandom_range(0, 1) * 4095);
    end
    return it;
  endfunction

  task automatic match_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_report(input track_report_t want, input logic kind,
                              input logic [OUT_W-1:0] data);
    out_word_t got;
    got = out_word_t'(data);
    match_field("result_kind", want.kind, kind);
    match_field("detected", want.detected, got.detected);
    match_field("center_x_half", want.cx, got.cx);
    match_field("center_y_half", want.cy, got.cy);
    match_field("target_width", want.w, got.w);
    match_field("target_height", want.h, got.h);
    match_field("target_column", want.col, got.col);
    match_field("misses", want.misses, got.misses);
    match_field("tracker_reset", want.rst, got.rst);
  endtask

  // present one item, hold until taken, then predict its report
  task automatic push_item(input det_item_t it, input bit typed, input track_report_t want);
    track_report_t r;
    bit got;
    if (gap_next > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_next) @(posedge clk);
    end
    gap_next  = 0;
    in_tvalid <= 1'b1;
    in_tuser  <= {it.person, it.cmd};
    in_tdata  <= IN_W'({it.y1, it.y0, it.x1, it.x0});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = step_tracker(it, r);
    if (typed) tracker_reports = {tracker_reports, want};
    else if (got) tracker_reports = {tracker_reports, r};
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      ready_sel  = $urandom_range(0, 9);
      gap_next   = (ready_sel < 5) ? $urandom_range(1, 4) :
                   (ready_sel < 8) ? $urandom_range(5, 40) : 0;
    end
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    gap_next   = 0;
    burst_left = 0;
  endtask

  task automatic drain_reports();
    while (tracker_reports.size() != 0) @(posedge clk);
    // let a box that yields nothing finish its distance pass
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gnbt_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [gnbt_pkg::CFG_DATA_BITS-1:0] val);
    idle_input();
    drain_reports();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gnbt_pkg::CFG_GATE) gate_cfg = val[11:0];
    else miss_cfg = val[7:0];
  endtask

  // result side: stall in runs of random length
  always @(posedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin out_tready <= 1'b1; ready_left = $urandom_range(1, 40); end
        4, 5, 6:    begin out_tready <= 1'b0; ready_left = $urandom_range(1, 6); end
        7:          begin out_tready <= 1'b0; ready_left = $urandom_range(10, 25); end
        default:    begin out_tready <= 1'b1; ready_left = $urandom_range(60, 200); end
      endcase
    end else begin
      ready_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (tracker_reports.size() == 0) begin
        fault_count++;
        $display("%0t: report expected none actual kind %0d data %h", $time, out_tuser,
                 out_tdata);
      end else begin
        head = tracker_reports.pop_front();
        check_report(head, out_tuser, out_tdata);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int nb, dry, counted, g, m;
    det_item_t it;
    // frame end straight after reset
    add_item(mk_item(gnbt_pkg::CMD_EOF, 1'b0, 0, 0, 0, 0));
    add_report(mk_report(gnbt_pkg::KIND_SUMMARY, 1'b0, 0, 0, 0, 0, 1, 1'b0));
    // first box without a reference is taken at the gate
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 100, 200, 50, 150));
    add_report(mk_report(gnbt_pkg::KIND_UPDATE, 1'b1, 300, 200, 100, 100, 1, 1'b0));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b0, 0, 4095, 4095, 0));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 102, 202, 50, 150));
    add_item(mk_item(gnbt_pkg::CMD_EOF, 1'b1, 4095, 4095, 4095, 4095));
    add_report(mk_report(gnbt_pkg::KIND_SUMMARY, 1'b1, 300, 200, 100, 100, 0, 1'b0));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 101, 201, 50, 150));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 100, 200, 50, 150));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 0, 0, 0, 0));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 4095, 4095, 4095, 4095));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 4095, 0, 4095, 0));
    add_item(mk_item(gnbt_pkg::CMD_EOF, 1'b0, 0, 0, 0, 0));
    // widest gate: whole-image box, then an inverted one at the far corner
    add_reg(gnbt_pkg::CFG_GATE, 4095);
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 0, 4095, 0, 4095));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 4095, 0, 4095, 0));
    // miss limit zero: the first missed frame resets the tracker
    add_reg(gnbt_pkg::CFG_MISS, 0);
    add_item(mk_item(gnbt_pkg::CMD_EOF, 1'b0, 0, 0, 0, 0));
    add_item(mk_item(gnbt_pkg::CMD_EOF, 1'b0, 0, 0, 0, 0));
    add_item(mk_item(gnbt_pkg::CMD_EOF, 1'b0, 0, 0, 0, 0));
    add_report(mk_report(gnbt_pkg::KIND_SUMMARY, 1'b0, 0, 0, 0, 0, 0, 1'b1));
    // closed gate accepts nothing
    add_reg(gnbt_pkg::CFG_GATE, 0);
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 10, 20, 10, 20));
    add_item(mk_item(gnbt_pkg::CMD_EOF, 1'b0, 0, 0, 0, 0));
    // narrowest open gate, longest miss run
    add_reg(gnbt_pkg::CFG_GATE, 1);
    add_reg(gnbt_pkg::CFG_MISS, 255);
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 0, 0, 0, 0));
    add_item(mk_item(gnbt_pkg::CMD_BOX, 1'b1, 5, 9, 5, 9));
    add_item(mk_item(gnbt_pkg::CMD_EOF, 1'b0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) write_reg(script[i].reg_idx, script[i].reg_val);
      else push_item(script[i].item, script[i].typed, script[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0:       g = 4095;
        1:       g = 1;
        2:       g = $urandom_range(1, 4095);
        default: g = $urandom_range(20, 300);
      endcase
      case ($urandom_range(0, 4))
        0:       m = 0;
        1:       m = 255;
        2:       m = $urandom_range(0, 255);
        default: m = $urandom_range(0, 6);
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(gnbt_pkg::CFG_GATE, g[gnbt_pkg::CFG_DATA_BITS-1:0]);
        write_reg(gnbt_pkg::CFG_MISS, m[gnbt_pkg::CFG_DATA_BITS-1:0]);
      end else begin
        write_reg(gnbt_pkg::CFG_MISS, m[gnbt_pkg::CFG_DATA_BITS-1:0]);
        write_reg(gnbt_pkg::CFG_GATE, g[gnbt_pkg::CFG_DATA_BITS-1:0]);
      end
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // occasional run of empty frames to walk the miss counter up
        dry = ($urandom_range(0, 14) == 0) ? $urandom_range(2, 14) : 0;
        repeat (dry) begin
          push_item(mk_item(gnbt_pkg::CMD_EOF, 1'($urandom_range(0, 1)),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095)), 1'b0, '0);
          counted++;
        end
        nb = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        repeat (nb) begin
          it = random_box();
          push_item(it, 1'b0, '0);
          if (it.person) counted++;
        end
        push_item(mk_item(gnbt_pkg::CMD_EOF, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095)), 1'b0, '0);
        counted++;
        // move the scene: mostly drift, now and then jump
        if ($urandom_range(0, 19) == 0) begin
          sc_x = $urandom_range(0, 4095);
          sc_y = $urandom_range(0, 4095);
          sc_w = $urandom_range(4, 400);
          sc_h = $urandom_range(4, 600);
        end else begin
          sc_x = clip(sc_x + int'($urandom_range(0, 16)) - 8);
          sc_y = clip(sc_y + int'($urandom_range(0, 16)) - 8);
        end
      end
    end

    idle_input();
    drain_reports();
    if (fault_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- gated_nearest_box_tracker.f -----
+incdir+rtl
rtl/gnbt_pkg.sv
rtl/gnbt_dist.sv
rtl/gated_nearest_box_tracker.sv
rtl/gnbt_checker.sv
tb/gated_nearest_box_tracker_test.sv
